### sv/sbss_pkg.sv
// Shared types and constants for the stereo biquad and sine shaper unit.
// Holds the payload structs, register indexes and the sequencer enums.
// No dependencies.
package sbss_pkg;

  localparam int SampleWidth  = 24;
  localparam int CoefWidth    = 24;
  localparam int AmtWidth     = 17;
  localparam int CfgIdxWidth  = 3;
  localparam int DefSineDepth = 1024;

  typedef struct packed {
    logic signed [SampleWidth-1:0] left_sample;
    logic signed [SampleWidth-1:0] right_sample;
  } sample_in_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] left_out;
    logic signed [SampleWidth-1:0] right_out;
  } sample_out_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COEF_A0         = 3'd0,
    REG_FEEDBACK_ONE    = 3'd1,
    REG_FEEDBACK_TWO    = 3'd2,
    REG_POSITIVE_AMOUNT = 3'd3,
    REG_NEGATIVE_AMOUNT = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_POST,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    PH_FF,
    PH_B1,
    PH_B2,
    PH_IDX1,
    PH_IDX2,
    PH_LIN
  } phase_e;

endpackage

### sv/stereo_biquad_sine_saturator_unit.sv
// Top level: stereo biquad lowpass followed by an asymmetric sine shaper.
// Uses sbss_pkg for payload types, register indexes and sequencer enums.
//
// Channel  | Handshake                | Payload
// ---------+--------------------------+------------------------------
// input    | in_valid_i / in_ready_o  | in_data_i (left, right sample)
// output   | out_valid_o / out_ready_i| out_data_o (left, right out)
// config   | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A frame is taken only in the idle state, once the previous one has been worked through.
// Each channel runs six products through one shift-and-add multiplier that retires one
// multiplier bit per cycle.
// Reset clears the filter state, the sequencer and the config registers; the sine table is a ROM.
// A new frame is taken while the previous result still waits for transfer, and the
// block stalls in its last cycle until that older result has gone.
module stereo_biquad_sine_saturator_unit #(
  parameter int SineDepth = sbss_pkg::DefSineDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  sbss_pkg::sample_in_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output sbss_pkg::sample_out_t               out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sbss_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [sbss_pkg::CoefWidth-1:0]      cfg_data_i
);

  localparam int SW      = sbss_pkg::SampleWidth;
  localparam int CW      = sbss_pkg::CoefWidth;
  localparam int AW      = sbss_pkg::AmtWidth;
  localparam int StW     = SW + 16;
  localparam int StX     = StW + 3;
  localparam int SwX     = SW + 2;
  localparam int FfShift = CW - 9;
  localparam int BShift  = CW - 2;
  localparam int XsShift = 7;
  localparam int IdxShift = SW + 15;
  localparam int LinShift = 16;
  localparam int PW      = StW + CW;
  localparam int MbW     = CW;
  localparam int IdxW    = $clog2(SineDepth + 1);
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam logic signed [StX-1:0] StMax = {4'b0000, {(StW-1){1'b1}}};
  localparam logic signed [StX-1:0] StMin = {4'b1111, {(StW-1){1'b0}}};
  localparam logic signed [SwX-1:0] SwMax = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SwX-1:0] SwMin = {3'b111, {(SW-1){1'b0}}};
  localparam logic [StW-1:0] XsPosLim = {{(StW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [StW-1:0] XsNegLim = {{(StW-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
  localparam logic [AW-1:0] AmtOne = {1'b1, {(AW-1){1'b0}}};

  typedef logic [SW-1:0] rom_t [SineDepth+1];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] mag;
    longint      sum;
    for (int i = 0; i <= SineDepth; i++) begin
      th  = (HalfPiQ30 * 64'(i) + 64'(SineDepth / 2)) / 64'(SineDepth);
      th2 = (th * th) >> 30;
      mag = th;
      sum = longint'(th);
      for (int k = 1; k <= 12; k++) begin
        mag = ((mag * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r[i] = SW'(((64'(sum) << (SW - 1)) + HalfPiQ30 / 2) / HalfPiQ30);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  function automatic logic signed [StW-1:0] sat_st(logic signed [StX-1:0] v);
    if (v > StMax) begin
      return StMax[StW-1:0];
    end else if (v < StMin) begin
      return StMin[StW-1:0];
    end
    return v[StW-1:0];
  endfunction

  sbss_pkg::state_e state_q, state_d;
  sbss_pkg::phase_e phase_q;
  logic ch_q;
  logic fin_take;

  sbss_pkg::sample_in_t  in_q;
  sbss_pkg::sample_out_t res_q, out_q;
  logic out_valid_q;

  logic [CW-2:0]        a0_q;
  logic signed [CW-1:0] b1_q, b2_q;
  logic [AW-1:0]        pamt_q, namt_q;

  logic signed [StW-1:0] s1_q [2];
  logic signed [StW-1:0] s2_q [2];
  logic signed [StW-1:0] a0x_q, a1x_q, y_q;
  logic signed [SW-1:0]  xs_q;
  logic [AW-1:0]         m_q;
  logic [IdxW-1:0]       idx_q;
  logic [SW-1:0]         rom_q;

  logic [PW-1:0]  mul_a_q, mul_p_q;
  logic [MbW-1:0] mul_b_q;

  logic signed [SW-1:0] x_cur;
  logic [SW-1:0]        x_mag, xs_mag;
  logic [StW-1:0]       y_mag;
  logic [CW-1:0]        b1_mag, b2_mag;
  logic [PW-1:0]        ff_a0m, ff_a1m, yb_m, idx_full, lin_m;
  logic signed [StW-1:0] ff_a0x, ff_a1x, ff_y;
  logic signed [StX-1:0] yb_s;
  logic [StW-1:0]        ym_r;
  logic signed [SW-1:0]  xs_c;
  logic [AW-1:0]         amt_c;
  logic signed [SwX-1:0] lin_s, tab_s, res_s;
  logic signed [SW-1:0]  res_c;
  logic [IdxW-1:0]       idx_c;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbss_pkg::ST_IDLE:  if (in_valid_i) state_d = sbss_pkg::ST_SETUP;
      sbss_pkg::ST_SETUP: state_d = sbss_pkg::ST_MUL;
      sbss_pkg::ST_MUL:   if (mul_b_q == '0) state_d = sbss_pkg::ST_POST;
      sbss_pkg::ST_POST: begin
        if (phase_q == sbss_pkg::PH_LIN && ch_q) begin
          state_d = sbss_pkg::ST_FIN;
        end else begin
          state_d = sbss_pkg::ST_SETUP;
        end
      end
      sbss_pkg::ST_FIN:   if (!out_valid_q || out_ready_i) state_d = sbss_pkg::ST_IDLE;
      default:            state_d = sbss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == sbss_pkg::ST_IDLE);
    cfg_ready_o = 1'b1;
    fin_take    = (state_q == sbss_pkg::ST_FIN) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    x_cur  = ch_q ? in_q.right_sample : in_q.left_sample;
    x_mag  = x_cur[SW-1] ? SW'(-x_cur) : SW'(x_cur);
    xs_mag = xs_q[SW-1] ? SW'(-xs_q) : SW'(xs_q);
    y_mag  = y_q[StW-1] ? StW'(-y_q) : StW'(y_q);
    b1_mag = b1_q[CW-1] ? CW'(-b1_q) : CW'(b1_q);
    b2_mag = b2_q[CW-1] ? CW'(-b2_q) : CW'(b2_q);

    ff_a0m = (mul_p_q + (PW'(1) << (FfShift - 1))) >> FfShift;
    ff_a1m = ((mul_p_q << 1) + (PW'(1) << (FfShift - 1))) >> FfShift;
    ff_a0x = x_cur[SW-1] ? -$signed(ff_a0m[StW-1:0]) : $signed(ff_a0m[StW-1:0]);
    ff_a1x = x_cur[SW-1] ? -$signed(ff_a1m[StW-1:0]) : $signed(ff_a1m[StW-1:0]);
    ff_y   = sat_st(StX'(ff_a0x) + StX'(s1_q[ch_q]));

    yb_m = (mul_p_q + (PW'(1) << (BShift - 1))) >> BShift;
    if (y_q[StW-1] ^ ((phase_q == sbss_pkg::PH_B1) ? b1_q[CW-1] : b2_q[CW-1])) begin
      yb_s = -$signed({1'b0, yb_m[StW+1:0]});
    end else begin
      yb_s = $signed({1'b0, yb_m[StW+1:0]});
    end

    ym_r = (y_mag + (StW'(1) << (XsShift - 1))) >> XsShift;
    if (y_q[StW-1]) begin
      xs_c = (ym_r > XsNegLim) ? SwMin[SW-1:0] : SW'(-$signed(ym_r));
    end else begin
      xs_c = (ym_r > XsPosLim) ? SwMax[SW-1:0] : SW'(ym_r);
    end
    amt_c = (xs_c > 0) ? pamt_q : namt_q;
    if (amt_c > AmtOne) begin
      amt_c = AmtOne;
    end

    idx_full = (mul_p_q + (PW'(1) << (IdxShift - 1))) >> IdxShift;
    idx_c = (idx_full > PW'(SineDepth)) ? IdxW'(SineDepth) : idx_full[IdxW-1:0];

    lin_m = (mul_p_q + (PW'(1) << (LinShift - 1))) >> LinShift;
    lin_s = xs_q[SW-1] ? -$signed({2'b00, lin_m[SW-1:0]}) : $signed({2'b00, lin_m[SW-1:0]});
    tab_s = xs_q[SW-1] ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
    res_s = tab_s + lin_s;
    if (res_s > SwMax) begin
      res_c = SwMax[SW-1:0];
    end else if (res_s < SwMin) begin
      res_c = SwMin[SW-1:0];
    end else begin
      res_c = res_s[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbss_pkg::ST_IDLE;
      phase_q     <= sbss_pkg::PH_FF;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      a0_q        <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      pamt_q      <= '0;
      namt_q      <= '0;
      s1_q[0]     <= '0;
      s1_q[1]     <= '0;
      s2_q[0]     <= '0;
      s2_q[1]     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          sbss_pkg::REG_COEF_A0:         a0_q   <= cfg_data_i[CW-2:0];
          sbss_pkg::REG_FEEDBACK_ONE:    b1_q   <= $signed(cfg_data_i);
          sbss_pkg::REG_FEEDBACK_TWO:    b2_q   <= $signed(cfg_data_i);
          sbss_pkg::REG_POSITIVE_AMOUNT: pamt_q <= cfg_data_i[AW-1:0];
          sbss_pkg::REG_NEGATIVE_AMOUNT: namt_q <= cfg_data_i[AW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        ch_q    <= 1'b0;
        phase_q <= sbss_pkg::PH_FF;
      end
      if (state_q == sbss_pkg::ST_POST) begin
        unique case (phase_q)
          sbss_pkg::PH_FF:   phase_q <= sbss_pkg::PH_B1;
          sbss_pkg::PH_B1: begin
            phase_q     <= sbss_pkg::PH_B2;
            s1_q[ch_q]  <= sat_st(StX'(a1x_q) - yb_s + StX'(s2_q[ch_q]));
          end
          sbss_pkg::PH_B2: begin
            phase_q     <= sbss_pkg::PH_IDX1;
            s2_q[ch_q]  <= sat_st(StX'(a0x_q) - yb_s);
          end
          sbss_pkg::PH_IDX1: phase_q <= sbss_pkg::PH_IDX2;
          sbss_pkg::PH_IDX2: phase_q <= sbss_pkg::PH_LIN;
          sbss_pkg::PH_LIN: begin
            phase_q <= sbss_pkg::PH_FF;
            ch_q    <= ~ch_q;
          end
          default: phase_q <= sbss_pkg::PH_FF;
        endcase
      end
      if (fin_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SineRom[idx_q];
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fin_take) begin
      out_q <= res_q;
    end
    if (state_q == sbss_pkg::ST_SETUP) begin
      mul_p_q <= '0;
      case (phase_q)
        sbss_pkg::PH_FF: begin
          mul_a_q <= PW'(x_mag);
          mul_b_q <= MbW'(a0_q);
        end
        sbss_pkg::PH_B1: begin
          mul_a_q <= PW'(y_mag);
          mul_b_q <= b1_mag;
        end
        sbss_pkg::PH_B2: begin
          mul_a_q <= PW'(y_mag);
          mul_b_q <= b2_mag;
        end
        sbss_pkg::PH_IDX1: begin
          mul_a_q <= PW'(xs_mag);
          mul_b_q <= MbW'(m_q);
        end
        sbss_pkg::PH_IDX2: begin
          mul_a_q <= mul_p_q;
          mul_b_q <= MbW'(SineDepth);
        end
        default: begin
          mul_a_q <= PW'(xs_mag);
          mul_b_q <= MbW'(AmtOne - m_q);
        end
      endcase
    end else if (state_q == sbss_pkg::ST_MUL && mul_b_q != '0) begin
      if (mul_b_q[0]) begin
        mul_p_q <= mul_p_q + mul_a_q;
      end
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
    if (state_q == sbss_pkg::ST_POST) begin
      case (phase_q)
        sbss_pkg::PH_FF: begin
          a0x_q <= ff_a0x;
          a1x_q <= ff_a1x;
          y_q   <= ff_y;
        end
        sbss_pkg::PH_B2: begin
          xs_q <= xs_c;
          m_q  <= amt_c;
        end
        sbss_pkg::PH_IDX2: idx_q <= idx_c;
        sbss_pkg::PH_LIN: begin
          if (ch_q) begin
            res_q.right_out <= res_c;
          end else begin
            res_q.left_out <= res_c;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == sbss_pkg::ST_SETUP))
    else $error("Accepted frame did not start the sequencer.");

  a_mul_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbss_pkg::ST_MUL && mul_b_q != '0) |=> (mul_b_q == ($past(mul_b_q) >> 1)))
    else $error("Multiplier operand did not advance by one bit.");

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take |=> out_valid_q)
    else $error("Finished frame was not presented.");

  a_post_from_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbss_pkg::ST_POST) |-> ($past(state_q) == sbss_pkg::ST_MUL))
    else $error("Result step entered without a finished product.");

endmodule
